/* hw/rtl/dual_motor_pd_speed_loop_top_defines.svh */
// assertion macros shared by the speed loop checker
`ifndef DUAL_MOTOR_PD_SPEED_LOOP_TOP_DEFINES_SVH
`define DUAL_MOTOR_PD_SPEED_LOOP_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while rst is high
`define DMPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet while rst is high
`define DMPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dmpd_pkg.sv */
// shared types, constants and control program of the dual motor speed loop
package dmpd_pkg;

  // field widths
  localparam int COUNT_W    = 16;
  localparam int TARGET_W   = 8;
  localparam int DUTY_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // default fixed-point format
  localparam int FRAC_BITS_DEF = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_LEFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_RIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_RIGHT = 3'd5;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] KP_LEFT_RST     = 16'd7654;
  localparam logic [CFG_DATA_W-1:0] KD_LEFT_RST     = 16'd3098;
  localparam logic [CFG_DATA_W-1:0] KP_RIGHT_RST    = 16'd192;
  localparam logic [CFG_DATA_W-1:0] KD_RIGHT_RST    = 16'd31;
  localparam logic [CFG_DATA_W-1:0] LIMIT_LEFT_RST  = 16'd0;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RIGHT_RST = 16'd0;

  // program layout: eight steps per motor, then the finish step
  localparam int STEP_W = 5;
  localparam int PH_W   = 3;
  localparam logic [STEP_W-1:0] UA_START = 5'd0;
  localparam logic [STEP_W-1:0] UA_END   = 5'd16;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MS_KP_ERR_LO = 2'd0,
    MS_KP_ERR_HI = 2'd1,
    MS_KD_D50_LO = 2'd2,
    MS_KD_D50_HI = 2'd3
  } mul_src_t;

  // sequencing of the next step
  typedef enum logic [1:0] {
    J_NEXT  = 2'd0,
    J_NOPID = 2'd1,
    J_END   = 2'd2
  } jump_t;

  // phases of one motor's update
  typedef enum logic [PH_W-1:0] {
    PH_TGT   = 3'd0,
    PH_ERR   = 3'd1,
    PH_DIFF  = 3'd2,
    PH_KP_HI = 3'd3,
    PH_KD_LO = 3'd4,
    PH_KD_HI = 3'd5,
    PH_ACC   = 3'd6,
    PH_UPD   = 3'd7
  } phase_t;

  // datapath controls of one step
  typedef struct packed {
    logic     motor;
    logic     ld_tgt;
    logic     ld_err;
    logic     ld_diff;
    logic     mul_en;
    mul_src_t mul_src;
    logic     acc_en;
    logic     upd;
  } ctrl_t;

  // one control word
  typedef struct packed {
    ctrl_t ctrl;
    jump_t jmp;
  } uword_t;

  // control store
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    phase_t ph;
    w = '0;
    ph = phase_t'(step[PH_W-1:0]);
    if (step[STEP_W-1]) begin
      w.jmp = J_END;
    end else begin
      w.ctrl.motor = step[PH_W];
      unique case (ph)
        PH_TGT: begin
          w.ctrl.ld_tgt = 1'b1;
          w.jmp = step[PH_W] ? J_NEXT : J_NOPID;
        end
        PH_ERR: begin
          w.ctrl.ld_err = 1'b1;
        end
        PH_DIFF: begin
          w.ctrl.ld_diff = 1'b1;
          w.ctrl.mul_en  = 1'b1;
          w.ctrl.mul_src = MS_KP_ERR_LO;
        end
        PH_KP_HI: begin
          w.ctrl.mul_en  = 1'b1;
          w.ctrl.mul_src = MS_KP_ERR_HI;
          w.ctrl.acc_en  = 1'b1;
        end
        PH_KD_LO: begin
          w.ctrl.mul_en  = 1'b1;
          w.ctrl.mul_src = MS_KD_D50_LO;
          w.ctrl.acc_en  = 1'b1;
        end
        PH_KD_HI: begin
          w.ctrl.mul_en  = 1'b1;
          w.ctrl.mul_src = MS_KD_D50_HI;
          w.ctrl.acc_en  = 1'b1;
        end
        PH_ACC: begin
          w.ctrl.acc_en = 1'b1;
        end
        PH_UPD: begin
          w.ctrl.upd = 1'b1;
        end
        default: begin
          w.jmp = J_END;
        end
      endcase
    end
    return w;
  endfunction

endpackage

/* hw/rtl/dmpd_if.sv */
// handshake channels of the speed loop: control ticks in, duty results out
interface dmpd_tick_if;
  logic                                valid;
  logic                                ready;
  logic [dmpd_pkg::COUNT_W-1:0]        pulse_count;
  logic signed [dmpd_pkg::TARGET_W-1:0] target_left;
  logic signed [dmpd_pkg::TARGET_W-1:0] target_right;
  logic                                use_pid;

  modport source (
    output valid, pulse_count, target_left, target_right, use_pid,
    input  ready
  );
  modport sink (
    input  valid, pulse_count, target_left, target_right, use_pid,
    output ready
  );
endinterface

interface dmpd_result_if;
  logic                        valid;
  logic                        ready;
  logic [dmpd_pkg::DUTY_W-1:0] duty_left;
  logic [dmpd_pkg::DUTY_W-1:0] duty_right;
  logic                        forward_left;
  logic                        forward_right;
  logic                        loop_active;

  modport source (
    output valid, duty_left, duty_right, forward_left, forward_right, loop_active,
    input  ready
  );
  modport sink (
    input  valid, duty_left, duty_right, forward_left, forward_right, loop_active,
    output ready
  );
endinterface

/* hw/rtl/dmpd_sequencer.sv */
// step counter and control store walk of the speed loop program
module dmpd_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            use_pid,
  input  logic            out_free,
  output logic            busy,
  output logic            done,
  output dmpd_pkg::ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                      state;
  seq_state_t                      state_next;
  logic [dmpd_pkg::STEP_W-1:0]     step;
  logic [dmpd_pkg::STEP_W-1:0]     step_next;
  logic                            run_pid;
  dmpd_pkg::uword_t                uw;

  // current control word
  assign uw = dmpd_pkg::ucode(step);

  // next step and finish
  always_comb begin
    state_next = state;
    step_next  = step;
    done       = 1'b0;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RUN;
          step_next  = dmpd_pkg::UA_START;
        end
      end
      S_RUN: begin
        ctrl = uw.ctrl;
        unique case (uw.jmp)
          dmpd_pkg::J_NEXT: begin
            step_next = step + dmpd_pkg::STEP_W'(1);
          end
          dmpd_pkg::J_NOPID: begin
            step_next = run_pid ? step + dmpd_pkg::STEP_W'(1) : dmpd_pkg::UA_END;
          end
          dmpd_pkg::J_END: begin
            if (out_free) begin
              done       = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= dmpd_pkg::UA_START;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // loop enable of the tick in work
  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      run_pid <= use_pid;
    end
  end

  assign busy = (state == S_RUN);

endmodule

/* hw/rtl/dmpd_datapath.sv */
// registers, shared multiplier and accumulator of the speed loop
module dmpd_datapath #(
  parameter int FRAC_BITS = dmpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dmpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmpd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 start,
  input  logic [dmpd_pkg::COUNT_W-1:0]         pulse_count,
  input  logic signed [dmpd_pkg::TARGET_W-1:0] target_left,
  input  logic signed [dmpd_pkg::TARGET_W-1:0] target_right,
  input  logic                                 use_pid,
  input  dmpd_pkg::ctrl_t                      ctrl,
  input  logic                                 done,
  output logic [dmpd_pkg::DUTY_W-1:0]          duty_left,
  output logic [dmpd_pkg::DUTY_W-1:0]          duty_right,
  output logic                                 forward_left,
  output logic                                 forward_right,
  output logic                                 loop_active
);

  localparam int F    = FRAC_BITS;
  localparam int TW   = F + 7;                       // scaled target
  localparam int EW   = F + 18;                      // error
  localparam int DFW  = F + 19;                      // error difference
  localparam int D5W  = F + 25;                      // fifty times difference
  localparam int LOW  = 18;                          // low operand chunk
  localparam int BW   = (F + 7 > LOW + 1) ? F + 7 : LOW + 1;
  localparam int GW   = dmpd_pkg::GAIN_W + 1;
  localparam int PW   = GW + BW;                     // product
  localparam int SW   = F + 42;                      // increment sum
  localparam int IW   = SW - F;                      // increment after shift
  localparam int ACW  = dmpd_pkg::DUTY_W + F;        // accumulator
  localparam int AW   = ((IW > ACW + 1) ? IW : ACW + 1) + 1;
  localparam int EIW  = EW - F;                      // integer error
  localparam int FT1  = (2 ** FRAC_BITS + 2) / 5;
  localparam int FT2  = (2 * 2 ** FRAC_BITS + 2) / 5;
  localparam int FT3  = (3 * 2 ** FRAC_BITS + 2) / 5;
  localparam int FT4  = (4 * 2 ** FRAC_BITS + 2) / 5;
  localparam logic signed [EIW-1:0] E_MAX = EIW'(32767);
  localparam logic signed [EIW-1:0] E_MIN = EIW'(-32768);

  // configuration registers
  logic [dmpd_pkg::GAIN_W-1:0] kp_left, kd_left, kp_right, kd_right;
  logic [dmpd_pkg::DUTY_W-1:0] limit_left, limit_right;

  // tick registers
  logic [dmpd_pkg::COUNT_W-1:0]         last_count;
  logic [dmpd_pkg::COUNT_W-1:0]         delta;
  logic signed [dmpd_pkg::TARGET_W-1:0] tl, tr;
  logic                                 pid_q;

  // loop state
  logic signed [15:0] prev_left, prev_right;
  logic [ACW-1:0]     accum_left, accum_right;

  // working registers
  logic signed [EW-1:0]  err;
  logic signed [D5W-1:0] d50;
  logic signed [PW-1:0]  prod;
  logic                  prod_hi;
  logic signed [SW-1:0]  sum;

  // motor selection
  logic signed [dmpd_pkg::TARGET_W-1:0] t_sel;
  logic [dmpd_pkg::GAIN_W-1:0]          kp_sel, kd_sel;
  logic [dmpd_pkg::DUTY_W-1:0]          lim_sel;
  logic signed [15:0]                   prev_sel;
  logic [ACW-1:0]                       acc_sel;

  assign t_sel    = ctrl.motor ? tr : tl;
  assign kp_sel   = ctrl.motor ? kp_right : kp_left;
  assign kd_sel   = ctrl.motor ? kd_right : kd_left;
  assign lim_sel  = ctrl.motor ? limit_right : limit_left;
  assign prev_sel = ctrl.motor ? prev_right : prev_left;
  assign acc_sel  = ctrl.motor ? accum_right : accum_left;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_left     <= dmpd_pkg::KP_LEFT_RST;
      kd_left     <= dmpd_pkg::KD_LEFT_RST;
      kp_right    <= dmpd_pkg::KP_RIGHT_RST;
      kd_right    <= dmpd_pkg::KD_RIGHT_RST;
      limit_left  <= dmpd_pkg::LIMIT_LEFT_RST;
      limit_right <= dmpd_pkg::LIMIT_RIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dmpd_pkg::CFG_KP_LEFT:     kp_left     <= cfg_data;
        dmpd_pkg::CFG_KD_LEFT:     kd_left     <= cfg_data;
        dmpd_pkg::CFG_KP_RIGHT:    kp_right    <= cfg_data;
        dmpd_pkg::CFG_KD_RIGHT:    kd_right    <= cfg_data;
        dmpd_pkg::CFG_LIMIT_LEFT:  limit_left  <= cfg_data;
        dmpd_pkg::CFG_LIMIT_RIGHT: limit_right <= cfg_data;
        default: ;
      endcase
    end
  end

  // encoder delta and last count
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (start) begin
      last_count <= pulse_count;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      delta <= pulse_count - last_count;
      tl    <= target_left;
      tr    <= target_right;
      pid_q <= use_pid;
    end
  end

  // scaled target: 2*|t|*2^F / 5 rounded, split as 2*|t| = 5*q + r
  logic [dmpd_pkg::TARGET_W-1:0] t_mag;
  logic [8:0]                    m2;
  logic [16:0]                   m_mul;
  logic [5:0]                    q5;
  logic [8:0]                    r5_full;
  logic [F-1:0]                  frac;
  logic signed [TW-1:0]          tgt_pos;
  logic signed [TW-1:0]          tfx;

  assign t_mag   = t_sel[dmpd_pkg::TARGET_W-1] ? (~t_sel + 8'd1) : t_sel;
  assign m2      = {t_mag, 1'b0};
  assign m_mul   = 17'(m2) * 17'd205;
  assign q5      = m_mul[15:10];
  assign r5_full = m2 - (9'(q5) * 9'd5);

  always_comb begin
    case (r5_full[2:0])
      3'd1:    frac = F'(FT1);
      3'd2:    frac = F'(FT2);
      3'd3:    frac = F'(FT3);
      3'd4:    frac = F'(FT4);
      default: frac = '0;
    endcase
  end

  assign tgt_pos = $signed({1'b0, q5, frac});
  assign tfx     = t_sel[dmpd_pkg::TARGET_W-1] ? -tgt_pos : tgt_pos;

  // error and scaled difference
  logic signed [EW-1:0]   delta_fx;
  logic signed [F+15:0]   prev_fx;
  logic signed [DFW-1:0]  diff;
  logic signed [D5W-1:0]  diff_w;
  logic signed [D5W-1:0]  d50_next;

  assign delta_fx = $signed(EW'({delta, {F{1'b0}}}));
  assign prev_fx  = $signed({prev_sel, {F{1'b0}}});
  assign diff     = DFW'(err) - DFW'(prev_fx);
  assign diff_w   = D5W'(diff);
  assign d50_next = (diff_w <<< 5) + (diff_w <<< 4) + (diff_w <<< 1);

  always_ff @(posedge clk) begin
    if (ctrl.ld_tgt) begin
      err <= EW'(tfx);
    end else if (ctrl.ld_err) begin
      err <= err - delta_fx;
    end
    if (ctrl.ld_diff) begin
      d50 <= d50_next;
    end
  end

  // shared multiplier, gain times one operand chunk
  logic signed [GW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [PW-1:0] mul_full;

  always_comb begin
    case (ctrl.mul_src)
      dmpd_pkg::MS_KP_ERR_LO: begin
        a_op = $signed({1'b0, kp_sel});
        b_op = $signed(BW'({1'b0, err[LOW-1:0]}));
      end
      dmpd_pkg::MS_KP_ERR_HI: begin
        a_op = $signed({1'b0, kp_sel});
        b_op = BW'($signed(err[EW-1:LOW]));
      end
      dmpd_pkg::MS_KD_D50_LO: begin
        a_op = $signed({1'b0, kd_sel});
        b_op = $signed(BW'({1'b0, d50[LOW-1:0]}));
      end
      default: begin
        a_op = $signed({1'b0, kd_sel});
        b_op = BW'($signed(d50[D5W-1:LOW]));
      end
    endcase
  end

  assign mul_full = a_op * b_op;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod    <= mul_full;
      prod_hi <= (ctrl.mul_src == dmpd_pkg::MS_KP_ERR_HI) ||
                 (ctrl.mul_src == dmpd_pkg::MS_KD_D50_HI);
    end
  end

  // partial product accumulation
  logic signed [SW-1:0] addend;

  assign addend = prod_hi ? (SW'(prod) <<< LOW) : SW'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.ld_err) begin
      sum <= '0;
    end else if (ctrl.acc_en) begin
      sum <= sum + addend;
    end
  end

  // accumulator update with clamp to zero and limit
  logic signed [IW-1:0]  inc;
  logic signed [AW-1:0]  a_sum;
  logic signed [AW-1:0]  top_v;
  logic [ACW-1:0]        acc_new;

  assign inc   = $signed(sum[SW-1:F]);
  assign a_sum = AW'(inc) + $signed(AW'(acc_sel));
  assign top_v = $signed(AW'({lim_sel, {F{1'b0}}}));

  always_comb begin
    if (a_sum > top_v) begin
      acc_new = {lim_sel, {F{1'b0}}};
    end else if (a_sum < $signed(AW'(0))) begin
      acc_new = '0;
    end else begin
      acc_new = a_sum[ACW-1:0];
    end
  end

  // integer error truncated toward zero, saturated to 16 bits
  logic signed [EIW-1:0] e_floor;
  logic signed [EIW-1:0] e_tz;
  logic signed [15:0]    e_sat;

  assign e_floor = $signed(err[EW-1:F]);
  assign e_tz    = e_floor + $signed(EIW'(err[EW-1] && (err[F-1:0] != '0)));

  always_comb begin
    if (e_tz > E_MAX) begin
      e_sat = 16'sh7fff;
    end else if (e_tz < E_MIN) begin
      e_sat = -16'sh8000;
    end else begin
      e_sat = e_tz[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_left  <= '0;
      accum_right <= '0;
      prev_left   <= '0;
      prev_right  <= '0;
    end else if (ctrl.upd) begin
      if (ctrl.motor) begin
        accum_right <= acc_new;
        prev_right  <= e_sat;
      end else begin
        accum_left <= acc_new;
        prev_left  <= e_sat;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (done) begin
      duty_left     <= accum_left[ACW-1:F];
      duty_right    <= accum_right[ACW-1:F];
      forward_left  <= !tl[dmpd_pkg::TARGET_W-1] && (tl != '0);
      forward_right <= !tr[dmpd_pkg::TARGET_W-1] && (tr != '0);
      loop_active   <= pid_q;
    end
  end

endmodule

/* hw/rtl/dual_motor_pd_speed_loop_top.sv */
// top level of the dual motor incremental pd speed loop
// One tick beat in gives one result beat out. A tick with the loop enabled
// is accepted while idle, then a 17-step control program runs the left and
// the right motor in turn through a single shared gain-by-operand multiplier,
// four partial products per motor, followed by the clamped accumulator
// update. A tick with the loop disabled loads the left target and goes to
// the finish step. A new tick is taken once the program has finished, while
// the previous result may still sit in the result register; if that result
// has not been taken when the next one is ready, the program waits at its
// last step. Gains are unsigned with FRAC_BITS fractional bits, the limits
// are integers, and configuration writes belong between ticks.
module dual_motor_pd_speed_loop_top #(
  parameter int FRAC_BITS = dmpd_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dmpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmpd_pkg::CFG_DATA_W-1:0] cfg_data,
  dmpd_tick_if.sink                       tick,
  dmpd_result_if.source                   result
);

  logic            start;
  logic            busy;
  logic            done;
  logic            out_free;
  logic            result_valid;
  dmpd_pkg::ctrl_t ctrl;

  // tick handshake
  assign tick.ready = !busy;
  assign start      = tick.valid && !busy;

  // result slot is free when empty or being taken
  assign out_free = !result_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  assign result.valid = result_valid;

  // program sequencer
  dmpd_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .use_pid  (tick.use_pid),
    .out_free (out_free),
    .busy     (busy),
    .done     (done),
    .ctrl     (ctrl)
  );

  // datapath
  dmpd_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .pulse_count   (tick.pulse_count),
    .target_left   (tick.target_left),
    .target_right  (tick.target_right),
    .use_pid       (tick.use_pid),
    .ctrl          (ctrl),
    .done          (done),
    .duty_left     (result.duty_left),
    .duty_right    (result.duty_right),
    .forward_left  (result.forward_left),
    .forward_right (result.forward_right),
    .loop_active   (result.loop_active)
  );

endmodule

/* hw/rtl/dmpd_checker.sv */
// port-level checks of the speed loop, bound to the top level
`include "dual_motor_pd_speed_loop_top_defines.svh"

module dmpd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        tick_valid,
  input logic                        tick_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [dmpd_pkg::DUTY_W-1:0] duty_left,
  input logic [dmpd_pkg::DUTY_W-1:0] duty_right,
  input logic                        loop_active
);

  logic                        in_beat;
  logic                        out_beat;
  logic [1:0]                  pend;
  logic [dmpd_pkg::DUTY_W-1:0] last_left;
  logic [dmpd_pkg::DUTY_W-1:0] last_right;

  assign in_beat  = tick_valid && tick_ready;
  assign out_beat = result_valid && result_ready;

  // ticks taken and not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  // duties of the last result beat, zero out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
    end else if (out_beat) begin
      last_left  <= duty_left;
      last_right <= duty_right;
    end
  end

  // a stalled result stays offered
  `DMPD_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

  // a disabled tick reports the duties of the previous result
  `DMPD_ASSERT_IMP(a_hold_duty, out_beat && !loop_active, (duty_left == last_left) && (duty_right == last_right), "duty moved with loop disabled")

  // at most one tick in work plus one waiting result
  `DMPD_ASSERT_IMP(a_pend_bound, 1'b1, pend != 2'd3, "too many ticks in flight")

  // no result without a tick behind it
  `DMPD_ASSERT_IMP(a_no_orphan, result_valid, pend != 2'd0, "result without tick")

endmodule

bind dual_motor_pd_speed_loop_top dmpd_checker u_dmpd_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .duty_left    (result.duty_left),
  .duty_right   (result.duty_right),
  .loop_active  (result.loop_active)
);
